FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define AST_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and defaults of the binary buddy allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MIN_ORDER  = 10;
    localparam int MAX_ORDER  = 17;
    localparam int SLOT_COUNT = 128;
    localparam logic [31:0] BASE_RESET = 32'h2000_0000;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NO_FREE   = 3'd3;
    localparam logic [2:0] ST_NULL      = 3'd4;
    localparam logic [2:0] ST_OUTSIDE   = 3'd5;
    localparam logic [2:0] ST_MISALIGN  = 3'd6;
    localparam logic [2:0] ST_NOT_LIVE  = 3'd7;

    // datapath operations
    localparam logic [4:0] OP_NOP        = 5'd0;
    localparam logic [4:0] OP_CLEAR      = 5'd1;
    localparam logic [4:0] OP_LOAD       = 5'd2;
    localparam logic [4:0] OP_ROUND      = 5'd3;
    localparam logic [4:0] OP_SEARCH     = 5'd4;
    localparam logic [4:0] OP_HEAD_RD    = 5'd5;
    localparam logic [4:0] OP_HEAD_POP   = 5'd6;
    localparam logic [4:0] OP_SPLIT      = 5'd7;
    localparam logic [4:0] OP_GRANT      = 5'd8;
    localparam logic [4:0] OP_LIVE_RD    = 5'd9;
    localparam logic [4:0] OP_FREE       = 5'd10;
    localparam logic [4:0] OP_MPOP       = 5'd11;
    localparam logic [4:0] OP_WALK_START = 5'd12;
    localparam logic [4:0] OP_STEP       = 5'd13;
    localparam logic [4:0] OP_RD_LINK    = 5'd14;
    localparam logic [4:0] OP_UNLINK     = 5'd15;
    localparam logic [4:0] OP_PUSH       = 5'd16;
    localparam logic [4:0] OP_DONE       = 5'd17;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [17:0] rounded_size;
        logic [17:0] free_bytes;
        logic [17:0] largest_free;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] code;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       action;
        logic       size_zero;
        logic       fit;
        logic       top;
        logic       hv;
        logic       head_hit;
        logic       more;
        logic       link_v;
        logic       link_hit;
        logic       live_ok;
        logic       out_busy;
        logic [2:0] chk;
    } t_sts;

endpackage

FILE: hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer that steps the allocator datapath through one item at a time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_ROUND  = 4'd3;
    localparam logic [3:0] S_SEARCH = 4'd4;
    localparam logic [3:0] S_POPRD  = 4'd5;
    localparam logic [3:0] S_POP    = 4'd6;
    localparam logic [3:0] S_SPLIT  = 4'd7;
    localparam logic [3:0] S_LIVE   = 4'd8;
    localparam logic [3:0] S_MERGE  = 4'd9;
    localparam logic [3:0] S_MPOP   = 4'd10;
    localparam logic [3:0] S_WALK   = 4'd11;
    localparam logic [3:0] S_UNLINK = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0] r_state, n_state;
    logic [2:0] r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= bba_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd.op   = bba_pkg::OP_NOP;
        o_cmd.code = r_code;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = bba_pkg::OP_CLEAR;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bba_pkg::OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (!i_sts.action) begin
                    if (i_sts.size_zero) begin
                        n_code  = bba_pkg::ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ROUND;
                    end
                end else if (i_sts.chk != bba_pkg::ST_OK) begin
                    n_code  = i_sts.chk;
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_LIVE_RD;
                    n_state  = S_LIVE;
                end
            end
            S_ROUND: begin
                o_cmd.op = bba_pkg::OP_ROUND;
                if (i_sts.fit) begin
                    n_state = S_SEARCH;
                end else if (i_sts.top) begin
                    n_code  = bba_pkg::ST_TOO_LARGE;
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                o_cmd.op = bba_pkg::OP_SEARCH;
                if (i_sts.hv) begin
                    n_state = S_POPRD;
                end else if (i_sts.top) begin
                    n_code  = bba_pkg::ST_NO_FREE;
                    n_state = S_DONE;
                end
            end
            S_POPRD: begin
                o_cmd.op = bba_pkg::OP_HEAD_RD;
                n_state  = S_POP;
            end
            S_POP: begin
                o_cmd.op = bba_pkg::OP_HEAD_POP;
                n_state  = S_SPLIT;
            end
            S_SPLIT: begin
                if (i_sts.more) begin
                    o_cmd.op = bba_pkg::OP_SPLIT;
                end else begin
                    o_cmd.op = bba_pkg::OP_GRANT;
                    n_code   = bba_pkg::ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_LIVE: begin
                if (i_sts.live_ok) begin
                    o_cmd.op = bba_pkg::OP_FREE;
                    n_state  = S_MERGE;
                end else begin
                    n_code  = bba_pkg::ST_NOT_LIVE;
                    n_state = S_DONE;
                end
            end
            S_MERGE: begin
                if (i_sts.top || !i_sts.hv) begin
                    o_cmd.op = bba_pkg::OP_PUSH;
                    n_code   = bba_pkg::ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.head_hit) begin
                    o_cmd.op = bba_pkg::OP_HEAD_RD;
                    n_state  = S_MPOP;
                end else begin
                    o_cmd.op = bba_pkg::OP_WALK_START;
                    n_state  = S_WALK;
                end
            end
            S_MPOP: begin
                o_cmd.op = bba_pkg::OP_MPOP;
                n_state  = S_MERGE;
            end
            S_WALK: begin
                if (!i_sts.link_v) begin
                    o_cmd.op = bba_pkg::OP_PUSH;
                    n_code   = bba_pkg::ST_OK;
                    n_state  = S_DONE;
                end else if (i_sts.link_hit) begin
                    o_cmd.op = bba_pkg::OP_RD_LINK;
                    n_state  = S_UNLINK;
                end else begin
                    o_cmd.op = bba_pkg::OP_STEP;
                end
            end
            S_UNLINK: begin
                o_cmd.op = bba_pkg::OP_UNLINK;
                n_state  = S_MERGE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = bba_pkg::OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `AST_NEXT(a_accept_starts, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid,
              r_state == S_START, "accepted item did not start")
    `AST_SAME(a_done_only_free, i_clk, i_rst_n, o_cmd.op == bba_pkg::OP_DONE,
              !i_sts.out_busy, "result issued over a held result")

endmodule

FILE: hw/rtl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// free lists, link and live memories, counters and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_dp #(
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER,
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER,
    parameter int SLOT_COUNT = bba_pkg::SLOT_COUNT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_wdata,
    input  bba_pkg::t_in    i_in_data,
    input  bba_pkg::t_cmd   i_cmd,
    output bba_pkg::t_sts   o_sts,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bba_pkg::t_out   o_out_data
);

    localparam int OC = MAX_ORDER - MIN_ORDER + 1;
    localparam int LW = (OC > 1) ? $clog2(OC) : 1;
    localparam int PW = (MAX_ORDER > MIN_ORDER) ? (MAX_ORDER - MIN_ORDER) : 1;
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int FW = MAX_ORDER + 1;

    // head of each order's list
    logic [AW-1:0] r_head [OC];
    logic [OC-1:0] r_hv;
    logic [FW-1:0] r_free;
    logic [31:0]   r_base;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;
    bba_pkg::t_out r_out;

    // item and work registers
    logic          r_action;
    logic [31:0]   r_size;
    logic [31:0]   r_addr;
    logic [LW-1:0] r_lvl;
    logic [LW-1:0] r_want;
    logic [PW-1:0] r_slot;
    logic [AW-1:0] r_prev;
    logic [AW:0]   r_link;
    logic [4:0]    r_live;

    // memories: link has valid in msb
    logic [AW:0]   m_link [SLOT_COUNT];
    logic [4:0]    m_live [SLOT_COUNT];

    logic [32:0]   off;
    logic [PW-1:0] fslot;
    logic [PW-1:0] buddy;
    logic [PW-1:0] lo_slot;
    logic [LW-1:0] nl;
    logic [PW-1:0] nslot;
    logic          nslot_in;
    logic          slot_in;
    logic [AW:0]   lk_wdata;
    logic [AW-1:0] lk_waddr;
    logic          lk_we;
    logic [AW-1:0] lk_raddr;
    logic          lk_re;
    logic [17:0]   largest;
    logic [17:0]   rounded;
    logic [2:0]    chk;

    always_comb begin
        off     = {1'b0, r_addr} - {1'b0, r_base};
        fslot   = PW'(off >> MIN_ORDER);
        buddy   = r_slot ^ (PW'(1) << r_lvl);
        lo_slot = (buddy < r_slot) ? buddy : r_slot;
        nl      = r_lvl - LW'(1);
        nslot   = r_slot + (PW'(1) << nl);
        nslot_in = (32'(nslot) < 32'(SLOT_COUNT));
        slot_in  = (32'(r_slot) < 32'(SLOT_COUNT));
        if (r_addr == 32'd0) begin
            chk = bba_pkg::ST_NULL;
        end else if ((r_addr < r_base) || (off >= (33'(1) << MAX_ORDER))) begin
            chk = bba_pkg::ST_OUTSIDE;
        end else if (off[MIN_ORDER-1:0] != '0) begin
            chk = bba_pkg::ST_MISALIGN;
        end else begin
            chk = bba_pkg::ST_OK;
        end
    end

    // link memory port selection
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = r_clr;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = r_head[r_lvl];
        case (i_cmd.op)
            bba_pkg::OP_CLEAR: begin
                lk_we = 1'b1;
            end
            bba_pkg::OP_SPLIT: begin
                lk_we    = nslot_in;
                lk_waddr = AW'(nslot);
                lk_wdata = {r_hv[nl], r_head[nl]};
            end
            bba_pkg::OP_UNLINK: begin
                lk_we    = 1'b1;
                lk_waddr = r_prev;
                lk_wdata = r_link;
            end
            bba_pkg::OP_PUSH: begin
                lk_we    = slot_in;
                lk_waddr = AW'(r_slot);
                lk_wdata = {r_hv[r_lvl], r_head[r_lvl]};
            end
            bba_pkg::OP_HEAD_RD, bba_pkg::OP_WALK_START: begin
                lk_re = 1'b1;
            end
            bba_pkg::OP_STEP, bba_pkg::OP_RD_LINK: begin
                lk_re    = 1'b1;
                lk_raddr = r_link[AW-1:0];
            end
            default: begin
                lk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) m_link[lk_waddr] <= lk_wdata;
        if (lk_re) r_link <= m_link[lk_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bba_pkg::OP_CLEAR: m_live[r_clr] <= 5'd0;
            bba_pkg::OP_GRANT: m_live[AW'(r_slot)] <= 5'(32'(r_want) + MIN_ORDER);
            bba_pkg::OP_FREE:  m_live[AW'(r_slot)] <= 5'd0;
            default: begin
            end
        endcase
        if (i_cmd.op == bba_pkg::OP_LIVE_RD) begin
            r_live <= (32'(fslot) < 32'(SLOT_COUNT)) ? m_live[AW'(fslot)] : 5'd0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < OC; k++) r_head[k] <= '0;
            r_hv        <= OC'(1) << (OC - 1);
            r_free      <= FW'(1) << MAX_ORDER;
            r_base      <= bba_pkg::BASE_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            // a new result may replace one leaving in the same cycle
            if (i_cmd.op == bba_pkg::OP_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                bba_pkg::OP_CLEAR: r_clr <= r_clr + AW'(1);
                bba_pkg::OP_HEAD_POP: begin
                    r_head[r_lvl] <= r_link[AW-1:0];
                    r_hv[r_lvl]   <= r_link[AW];
                end
                bba_pkg::OP_MPOP: begin
                    r_head[r_lvl] <= r_link[AW-1:0];
                    r_hv[r_lvl]   <= r_link[AW];
                end
                bba_pkg::OP_SPLIT: begin
                    if (nslot_in) begin
                        r_head[nl] <= AW'(nslot);
                        r_hv[nl]   <= 1'b1;
                    end
                end
                bba_pkg::OP_PUSH: begin
                    if (slot_in) begin
                        r_head[r_lvl] <= AW'(r_slot);
                        r_hv[r_lvl]   <= 1'b1;
                    end
                end
                bba_pkg::OP_GRANT: r_free <= r_free - (FW'(1) << (32'(r_want) + MIN_ORDER));
                bba_pkg::OP_FREE:  r_free <= r_free + (FW'(1) << r_live);
                default: begin
                end
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bba_pkg::OP_LOAD: begin
                r_action <= i_in_data.action;
                r_size   <= i_in_data.request_size;
                r_addr   <= i_in_data.block_address;
                r_lvl    <= '0;
            end
            bba_pkg::OP_ROUND: begin
                if (o_sts.fit) r_want <= r_lvl;
                else           r_lvl  <= r_lvl + LW'(1);
            end
            bba_pkg::OP_SEARCH: begin
                if (r_hv[r_lvl]) r_slot <= PW'(r_head[r_lvl]);
                else             r_lvl  <= r_lvl + LW'(1);
            end
            bba_pkg::OP_SPLIT: r_lvl <= nl;
            bba_pkg::OP_LIVE_RD: r_slot <= fslot;
            bba_pkg::OP_FREE: r_lvl <= LW'(32'(r_live) - MIN_ORDER);
            bba_pkg::OP_MPOP, bba_pkg::OP_UNLINK: begin
                r_slot <= lo_slot;
                r_lvl  <= r_lvl + LW'(1);
            end
            bba_pkg::OP_WALK_START: r_prev <= r_head[r_lvl];
            bba_pkg::OP_STEP: r_prev <= r_link[AW-1:0];
            bba_pkg::OP_DONE: begin
                r_out.status          <= i_cmd.code;
                r_out.granted_address <= (!r_action && i_cmd.code == bba_pkg::ST_OK) ?
                                         r_base + (32'(r_slot) << MIN_ORDER) : 32'd0;
                r_out.rounded_size    <= rounded;
                r_out.free_bytes      <= 18'(r_free);
                r_out.largest_free    <= largest;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        largest = '0;
        for (int k = 0; k < OC; k++) begin
            if (r_hv[k]) largest = 18'(1) << (k + MIN_ORDER);
        end
        if (r_action || i_cmd.code == bba_pkg::ST_TOO_LARGE) rounded = '0;
        else if (i_cmd.code == bba_pkg::ST_ZERO) rounded = 18'(1) << MIN_ORDER;
        else rounded = 18'(1) << (32'(r_want) + MIN_ORDER);
    end

    always_comb begin
        o_sts.clr_last  = (32'(r_clr) == 32'(SLOT_COUNT - 1));
        o_sts.action    = r_action;
        o_sts.size_zero = (r_size == 32'd0);
        o_sts.fit       = ({1'b0, r_size} <= (33'(1) << (32'(r_lvl) + MIN_ORDER)));
        o_sts.top       = (32'(r_lvl) == OC - 1);
        o_sts.hv        = r_hv[r_lvl];
        o_sts.head_hit  = (32'(r_head[r_lvl]) == 32'(buddy));
        o_sts.more      = (r_lvl != r_want);
        o_sts.link_v    = r_link[AW];
        o_sts.link_hit  = (32'(r_link[AW-1:0]) == 32'(buddy));
        o_sts.live_ok   = (32'(r_live) >= MIN_ORDER) && (32'(r_live) <= MAX_ORDER);
        o_sts.out_busy  = r_out_valid && i_out_stall;
        o_sts.chk       = chk;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `AST_NEXT(a_done_sets_valid, i_clk, i_rst_n, i_cmd.op == bba_pkg::OP_DONE,
              r_out_valid, "result register not loaded")
    `AST_SAME(a_free_bounded, i_clk, i_rst_n, 1'b1, r_free <= (FW'(1) << MAX_ORDER),
              "free count beyond pool size")

endmodule

FILE: hw/rtl/binary_buddy_allocator.sv
// ----------------------------------------------------------------------------
// binary_buddy_allocator
// buddy allocator over a power-of-two pool with one result per request
// ----------------------------------------------------------------------------
// One request is worked at a time; each gives exactly one result. After reset
// a clearing pass walks every slot of the link and live memories while input
// stays stalled. An allocate rounds the size up order by order, searches the
// orders upward for a free block, pops it and splits it down to the rounded
// order; the rounding, search and split loops each run at most MAX_ORDER -
// MIN_ORDER + 1 times. A free checks the address, reads the live table and, at
// each merge level, pops the buddy when it heads its list or else walks the
// list entry by entry and unlinks it. Every list read and write goes through
// the link memory. The result register lets the next request be taken while a
// result still waits. pool_base moves the pool only and should be written while idle.
module binary_buddy_allocator #(
    parameter int MIN_ORDER  = bba_pkg::MIN_ORDER,
    parameter int MAX_ORDER  = bba_pkg::MAX_ORDER,
    parameter int SLOT_COUNT = bba_pkg::SLOT_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: pool base address
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    // request transfer
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bba_pkg::t_in  i_in_data,
    // result transfer
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bba_pkg::t_out o_out_data
);

    bba_pkg::t_cmd cmd;
    bba_pkg::t_sts sts;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // lists, memories and result register
    bba_dp #(
        .MIN_ORDER  (MIN_ORDER),
        .MAX_ORDER  (MAX_ORDER),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the buddy allocator against a cycle-free predictor of its free lists
// ----------------------------------------------------------------------------
// Requests go in through a randomly gapped sender. Results leave through a
// randomly stalled receiver. Each accepted request is run through a local
// copy of the free lists, the live table and the free byte count, and the
// outcome is queued. Each result transfer is compared field by field with
// the oldest queued outcome. Directed tests cover the edge cases first. A
// long random phase follows: mostly well formed allocate/free traffic, with
// bad frees and odd sizes mixed in, and the pool base moved several times.
module testbench;

    localparam int MIN_ORDER  = bba_pkg::MIN_ORDER;
    localparam int MAX_ORDER  = bba_pkg::MAX_ORDER;
    localparam int SLOT_COUNT = bba_pkg::SLOT_COUNT;
    localparam int ORDERS     = MAX_ORDER - MIN_ORDER + 1;
    localparam int POOL_BYTES = 1 << MAX_ORDER;
    localparam int STALL_LIMIT = 6000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    bba_pkg::t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    bba_pkg::t_out out_data;

    binary_buddy_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- model
    // local copy of the allocator state
    logic [31:0] pool_base_m;
    logic [7:0]  list_head_m [ORDERS];
    logic        head_ok_m   [ORDERS];
    logic [7:0]  link_m      [SLOT_COUNT];
    logic        link_ok_m   [SLOT_COUNT];
    int          live_m      [SLOT_COUNT];
    longint      free_total_m;

    bba_pkg::t_out pending_outcomes [$];
    int   live_slots [$];      // slots currently handed out, for well formed frees
    int   error_count = 0;
    bit   no_idle = 0;         // when set both sides run without gaps
    int   quiet_cycles = 0;

    function automatic void model_reset();
        pool_base_m = bba_pkg::BASE_RESET;
        for (int k = 0; k < ORDERS; k++) begin
            list_head_m[k] = '0;
            head_ok_m[k] = 1'b0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            link_m[i] = '0;
            link_ok_m[i] = 1'b0;
            live_m[i] = 0;
        end
        list_head_m[ORDERS-1] = '0;
        head_ok_m[ORDERS-1] = 1'b1;
        free_total_m = POOL_BYTES;
    endfunction

    function automatic void list_push(int k, int slot);
        if (slot >= SLOT_COUNT) return;
        link_m[slot] = list_head_m[k];
        link_ok_m[slot] = head_ok_m[k];
        list_head_m[k] = slot[7:0];
        head_ok_m[k] = 1'b1;
    endfunction

    function automatic int list_pop(int k);
        int s;
        s = list_head_m[k];
        list_head_m[k] = link_m[s];
        head_ok_m[k] = link_ok_m[s];
        return s;
    endfunction

    // unlink a buddy from its order's list, 1 when found
    function automatic bit list_unlink(int k, int slot);
        int prev;
        int nx;
        if (!head_ok_m[k]) return 0;
        if (list_head_m[k] == slot) begin
            void'(list_pop(k));
            return 1;
        end
        prev = list_head_m[k];
        for (int steps = 0; steps < SLOT_COUNT && link_ok_m[prev]; steps++) begin
            nx = link_m[prev];
            if (nx == slot) begin
                link_m[prev] = link_m[nx];
                link_ok_m[prev] = link_ok_m[nx];
                return 1;
            end
            prev = nx;
        end
        return 0;
    endfunction

    function automatic bba_pkg::t_out buddy_outcome(bba_pkg::t_in req);
        bba_pkg::t_out res;
        longint base;
        longint size;
        longint addr;
        longint off;
        int want;
        int have;
        int slot;
        int order;
        int buddy;
        res = '0;
        base = pool_base_m;
        if (!req.action) begin
            size = req.request_size;
            want = MIN_ORDER;
            while ((64'd1 << want) < size && want >= 0) begin
                want++;
                if (want > MAX_ORDER) want = -1;
            end
            if (size == 0) begin
                res.status = bba_pkg::ST_ZERO;
                res.rounded_size = 18'(1 << MIN_ORDER);
            end else if (want < 0) begin
                res.status = bba_pkg::ST_TOO_LARGE;
            end else begin
                res.rounded_size = 18'(1 << want);
                have = -1;
                for (int o = want; o <= MAX_ORDER; o++) begin
                    if (have < 0 && head_ok_m[o - MIN_ORDER]) have = o;
                end
                if (have < 0) begin
                    res.status = bba_pkg::ST_NO_FREE;
                end else begin
                    slot = list_pop(have - MIN_ORDER);
                    while (have > want) begin
                        have--;
                        list_push(have - MIN_ORDER, slot + (1 << (have - MIN_ORDER)));
                    end
                    live_m[slot] = want;
                    free_total_m -= longint'(1) << want;
                    res.granted_address = 32'(base + (longint'(slot) << MIN_ORDER));
                    live_slots.push_back(slot);
                end
            end
        end else begin
            addr = req.block_address;
            if (addr == 0) begin
                res.status = bba_pkg::ST_NULL;
            end else if (addr < base || addr - base >= POOL_BYTES) begin
                res.status = bba_pkg::ST_OUTSIDE;
            end else if (((addr - base) & ((1 << MIN_ORDER) - 1)) != 0) begin
                res.status = bba_pkg::ST_MISALIGN;
            end else begin
                off = addr - base;
                slot = int'(off >> MIN_ORDER);
                order = (slot < SLOT_COUNT) ? live_m[slot] : 0;
                if (order < MIN_ORDER || order > MAX_ORDER) begin
                    res.status = bba_pkg::ST_NOT_LIVE;
                end else begin
                    live_m[slot] = 0;
                    foreach (live_slots[i]) begin
                        if (live_slots[i] == slot) begin
                            live_slots.delete(i);
                            break;
                        end
                    end
                    free_total_m += longint'(1) << order;
                    while (order < MAX_ORDER) begin
                        buddy = slot ^ (1 << (order - MIN_ORDER));
                        if (!list_unlink(order - MIN_ORDER, buddy)) break;
                        if (buddy < slot) slot = buddy;
                        order++;
                    end
                    list_push(order - MIN_ORDER, slot);
                end
            end
        end
        res.free_bytes = 18'(free_total_m);
        for (int k = ORDERS - 1; k >= 0; k--) begin
            if (head_ok_m[k] && res.largest_free == 0) begin
                res.largest_free = 18'(1 << (k + MIN_ORDER));
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------- result checking
    int stall_left = 0;
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                bba_pkg::t_out exp_r;
                exp_r = pending_outcomes.pop_front();
                if (out_data.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, out_data.status);
                    error_count++;
                end
                if (out_data.granted_address !== exp_r.granted_address) begin
                    $error("granted_address: expected %h, actual %h",
                           exp_r.granted_address, out_data.granted_address);
                    error_count++;
                end
                if (out_data.rounded_size !== exp_r.rounded_size) begin
                    $error("rounded_size: expected %0d, actual %0d",
                           exp_r.rounded_size, out_data.rounded_size);
                    error_count++;
                end
                if (out_data.free_bytes !== exp_r.free_bytes) begin
                    $error("free_bytes: expected %0d, actual %0d",
                           exp_r.free_bytes, out_data.free_bytes);
                    error_count++;
                end
                if (out_data.largest_free !== exp_r.largest_free) begin
                    $error("largest_free: expected %0d, actual %0d",
                           exp_r.largest_free, out_data.largest_free);
                    error_count++;
                end
            end
            // new stall length drawn after each result transfer
            stall_left = no_idle ? 0 : $urandom_range(0, 7);
            out_stall <= (stall_left > 0);
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= (stall_left > 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    // one request transfer; valid stays high on return, drain or the next
    // send decides what happens to it
    task automatic send_request(bba_pkg::t_in req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (in_stall);
        pending_outcomes.push_back(buddy_outcome(req));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_pool_base(logic [31:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool_base_m = value;
    endtask

    task automatic do_alloc(logic [31:0] size);
        bba_pkg::t_in req;
        req.action = 1'b0;
        req.request_size = size;
        req.block_address = $urandom();
        send_request(req);
    endtask

    task automatic do_free(logic [31:0] addr);
        bba_pkg::t_in req;
        req.action = 1'b1;
        req.request_size = $urandom();
        req.block_address = addr;
        send_request(req);
    endtask

    function automatic logic [31:0] slot_addr(int slot);
        return pool_base_m + 32'(slot << MIN_ORDER);
    endfunction

    // zero, oversize and exact-pool requests, exhaustion
    task automatic test_size_edges();
        do_alloc(32'd0);
        do_alloc(32'hFFFF_FFFF);
        do_alloc(32'(POOL_BYTES + 1));
        do_alloc(32'(POOL_BYTES));
        do_alloc(32'd1);
        do_free(slot_addr(0));
        do_alloc(32'd1024);
    endtask

    // each rejection path of a free, in check order
    task automatic test_bad_frees();
        do_free(32'd0);
        do_free(pool_base_m - 32'd1024);
        do_free(pool_base_m + 32'(POOL_BYTES));
        do_free(pool_base_m + 32'd1025);
        do_free(pool_base_m + 32'd4096);
        do_free(slot_addr(0));
        do_free(slot_addr(0));
    endtask

    // splits down to minimum blocks, frees out of order to force list walks
    task automatic test_split_merge();
        for (int i = 0; i < 6; i++) do_alloc(32'd1);
        do_alloc(32'd1025);
        do_alloc(32'd3000);
        do_alloc(32'd65536);
        for (int i = 0; i < 4; i++) begin
            if (live_slots.size() > 0) begin
                do_free(slot_addr(live_slots[(i * 3) % live_slots.size()]));
            end
        end
        while (live_slots.size() > 0) do_free(slot_addr(live_slots[live_slots.size() - 1]));
    endtask

    task automatic random_request();
        int pick;
        int e;
        pick = $urandom_range(0, 99);
        if (pick < 48) begin
            e = $urandom_range(0, 3) == 0 ? $urandom_range(10, 17) : $urandom_range(0, 13);
            do_alloc($urandom_range(1, 1 << e));
        end else if (pick < 82 && live_slots.size() > 0) begin
            do_free(slot_addr(live_slots[$urandom_range(0, live_slots.size() - 1)]));
        end else if (pick < 86) begin
            do_free(pool_base_m + $urandom_range(0, POOL_BYTES - 1));
        end else if (pick < 90) begin
            do_free($urandom());
        end else if (pick < 93) begin
            do_alloc($urandom());
        end else if (pick < 95) begin
            do_alloc(32'd0);
        end else begin
            do_free(slot_addr($urandom_range(0, SLOT_COUNT - 1)));
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            random_request();
        end
        no_idle = 0;
    endtask

    // base moves, extremes included; the live table follows the slots
    task automatic test_base_moves();
        write_pool_base(32'h0000_0000);
        test_random(60);
        write_pool_base(32'hFFFF_FFFF);
        test_random(40);
        write_pool_base(32'hFFFE_0000);
        test_bad_frees();
        test_random(120);
        write_pool_base({15'($urandom_range(1, 32767)), 17'd0});
        test_random(200);
    endtask

    initial begin
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_size_edges();
        test_bad_frees();
        test_split_merge();
        test_random(300);
        test_base_moves();
        write_pool_base(bba_pkg::BASE_RESET);
        test_random(300);
        drain();
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dp.sv
hw/rtl/binary_buddy_allocator.sv
verif/testbench.sv
